// ----- sv/ffua_pkg.sv -----
// Shared types and constants for the first-fit unit allocator.
package ffua_pkg;

    localparam int MEM_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 10;

    localparam int SIZE_W  = 11;
    localparam int ID_W    = 10;
    localparam int START_W = 10;
    localparam int FREED_W = 11;
    localparam int CFG_W   = 11;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CFG_W-1:0]    UNITS_RESET   = 11'd1024;
    localparam logic [ADDR_W-3:0]   REG_UNITS_IDX = '0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_AFILL,
        S_FSCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   owner;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [START_W-1:0] start;
        logic [FREED_W-1:0] freed;
    } t_res;

endpackage

// ----- sv/first_fit_unit_allocator_top.sv -----
// Top level of the first-fit unit allocator: config register, sequencer, tag RAM, output stage.
// One request at a time; each scan reads the tag RAM one unit per cycle through its read port.
// Allocate hit: scan to the end of the first free run that fits, then fill it; miss: scan all managed units.
// Free: scan all MEM_UNITS units and clear the owner's tags; rejected or zero-size requests go straight to the result.
// o_ready rises again in the cycle after the result register takes the previous result.
// After reset the whole tag RAM is cleared to zero with o_ready low; config writes work.
module first_fit_unit_allocator_top #(
    parameter int MEM_UNITS  = ffua_pkg::MEM_UNITS_DEF,
    parameter int OWNER_BITS = ffua_pkg::OWNER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffua_pkg::ADDR_W-1:0]     paddr,
    input  logic [ffua_pkg::DATA_W-1:0]     pwdata,
    output logic [ffua_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_command,
    input  logic [ffua_pkg::SIZE_W-1:0]     i_request_size,
    input  logic [ffua_pkg::ID_W-1:0]       i_owner_id,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_success,
    output logic [ffua_pkg::START_W-1:0]    o_start_unit,
    output logic [ffua_pkg::FREED_W-1:0]    o_freed_units
);

    localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;

    logic [ffua_pkg::CFG_W-1:0] r_units, n_units;
    logic                       r_out_valid, n_out_valid;
    ffua_pkg::t_res             r_out, n_out;

    ffua_pkg::t_req   req;
    ffua_pkg::t_res   res;
    logic             res_valid;
    logic             res_ready;
    logic             reg_hit;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [OWNER_BITS-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [OWNER_BITS-1:0] rd_data;

    assign reg_hit = (paddr[ffua_pkg::ADDR_W-1:2] == ffua_pkg::REG_UNITS_IDX);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? ffua_pkg::DATA_W'(r_units) : '0;

    assign req.cmd   = i_command;
    assign req.size  = i_request_size;
    assign req.owner = i_owner_id;

    assign res_ready = !r_out_valid || i_ready;

    always_comb begin
        n_units = r_units;
        if (psel && penable && pwrite && pready && reg_hit) begin
            n_units = pwdata[ffua_pkg::CFG_W-1:0];
        end
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units     <= ffua_pkg::UNITS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_units     <= n_units;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_success     = r_out.ok;
    assign o_start_unit  = r_out.start;
    assign o_freed_units = r_out.freed;

    ffua_ctrl #(
        .MEM_UNITS  (MEM_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_req       (req),
        .i_units     (r_units),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    ffua_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (MEM_UNITS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ----- sv/ffua_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module ffua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/ffua_ctrl.sv -----
// Sequencer that scans, fills and clears the owner tag memory.
module ffua_ctrl #(
    parameter int MEM_UNITS  = ffua_pkg::MEM_UNITS_DEF,
    parameter int OWNER_BITS = ffua_pkg::OWNER_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_req_valid,
    output logic                                         o_req_ready,
    input  ffua_pkg::t_req                               i_req,
    input  logic [ffua_pkg::CFG_W-1:0]                   i_units,
    output logic                                         o_res_valid,
    input  logic                                         i_res_ready,
    output ffua_pkg::t_res                               o_res,
    output logic                                         o_wr_en,
    output logic [((MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1)-1:0] o_wr_addr,
    output logic [OWNER_BITS-1:0]                        o_wr_data,
    output logic                                         o_rd_en,
    output logic [((MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1)-1:0] o_rd_addr,
    input  logic [OWNER_BITS-1:0]                        i_rd_data
);

    localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int CW = $clog2(MEM_UNITS + 1);
    localparam int LW = (CW > ffua_pkg::SIZE_W) ? CW : ffua_pkg::SIZE_W;
    localparam logic [CW-1:0] DEPTH = CW'(MEM_UNITS);
    localparam logic [CW-1:0] LAST  = CW'(MEM_UNITS - 1);

    ffua_pkg::t_state r_state, n_state;

    logic                          r_cmd, n_cmd;
    logic [ffua_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [OWNER_BITS-1:0]         r_owner, n_owner;
    logic [CW-1:0]                 r_lim, n_lim;
    logic [CW-1:0]                 r_addr, n_addr;
    logic                          r_rvalid, n_rvalid;
    logic [AW-1:0]                 r_raddr, n_raddr;
    logic [CW-1:0]                 r_run, n_run;
    logic [AW-1:0]                 r_fill, n_fill;
    logic [AW-1:0]                 r_end, n_end;
    logic                          r_ok, n_ok;
    logic [AW-1:0]                 r_start, n_start;
    logic [CW-1:0]                 r_freed, n_freed;

    logic [OWNER_BITS-1:0] req_owner;
    logic [LW-1:0]         units_ext;
    logic [LW-1:0]         lim_ext;
    logic [CW-1:0]         req_lim;
    logic                  req_direct;
    logic [CW-1:0]         limit;
    logic                  issue;
    logic                  scan_end;
    logic [CW-1:0]         run_next;
    logic                  hit;
    logic                  tag_match;
    logic [AW-1:0]         hit_start;

    always_comb begin
        req_owner = OWNER_BITS'(i_req.owner);
        units_ext = LW'(i_units);
        lim_ext   = (units_ext > LW'(MEM_UNITS)) ? LW'(MEM_UNITS) : units_ext;
        req_lim   = CW'(lim_ext);
        if (i_req.cmd == ffua_pkg::CMD_FREE) begin
            req_direct = (req_owner == '0);
        end else begin
            req_direct = (req_owner == '0) || (i_req.size == '0) ||
                         (LW'(i_req.size) > lim_ext);
        end
        limit     = (r_cmd == ffua_pkg::CMD_FREE) ? DEPTH : r_lim;
        issue     = (r_addr < limit);
        scan_end  = !r_rvalid && !issue;
        run_next  = (i_rd_data == '0) ? (r_run + CW'(1)) : '0;
        hit       = r_rvalid && (LW'(run_next) == LW'(r_size));
        tag_match = r_rvalid && (i_rd_data == r_owner);
        hit_start = AW'(LW'(r_raddr) + LW'(1) - LW'(r_size));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffua_pkg::S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_state = ffua_pkg::S_IDLE;
                end
            end
            ffua_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    if (req_direct) begin
                        n_state = ffua_pkg::S_DONE;
                    end else if (i_req.cmd == ffua_pkg::CMD_FREE) begin
                        n_state = ffua_pkg::S_FSCAN;
                    end else begin
                        n_state = ffua_pkg::S_ASCAN;
                    end
                end
            end
            ffua_pkg::S_ASCAN: begin
                if (hit) begin
                    n_state = ffua_pkg::S_AFILL;
                end else if (scan_end) begin
                    n_state = ffua_pkg::S_DONE;
                end
            end
            ffua_pkg::S_AFILL: begin
                if (r_fill == r_end) begin
                    n_state = ffua_pkg::S_DONE;
                end
            end
            ffua_pkg::S_FSCAN: begin
                if (scan_end) begin
                    n_state = ffua_pkg::S_DONE;
                end
            end
            ffua_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = ffua_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffua_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_size   = r_size;
        n_owner  = r_owner;
        n_lim    = r_lim;
        n_addr   = r_addr;
        n_rvalid = r_rvalid;
        n_raddr  = r_raddr;
        n_run    = r_run;
        n_fill   = r_fill;
        n_end    = r_end;
        n_ok     = r_ok;
        n_start  = r_start;
        n_freed  = r_freed;

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_addr[AW-1:0];
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_addr[AW-1:0];

        case (r_state)
            ffua_pkg::S_CLEAR: begin
                o_wr_en = 1'b1;
                n_addr  = r_addr + CW'(1);
            end
            ffua_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_cmd    = i_req.cmd;
                    n_size   = i_req.size;
                    n_owner  = req_owner;
                    n_lim    = req_lim;
                    n_addr   = '0;
                    n_rvalid = 1'b0;
                    n_run    = '0;
                    n_start  = '0;
                    n_freed  = '0;
                    n_ok     = (i_req.cmd == ffua_pkg::CMD_FREE) ||
                               ((req_owner != '0) && (i_req.size == '0));
                end
            end
            ffua_pkg::S_ASCAN: begin
                o_rd_en  = issue;
                n_rvalid = issue;
                n_raddr  = r_addr[AW-1:0];
                if (issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (r_rvalid) begin
                    n_run = run_next;
                end
                if (hit) begin
                    n_ok    = 1'b1;
                    n_start = hit_start;
                    n_fill  = hit_start;
                    n_end   = r_raddr;
                end
            end
            ffua_pkg::S_AFILL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_fill;
                o_wr_data = r_owner;
                n_fill    = r_fill + AW'(1);
            end
            ffua_pkg::S_FSCAN: begin
                o_rd_en  = issue;
                n_rvalid = issue;
                n_raddr  = r_addr[AW-1:0];
                if (issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (tag_match) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_raddr;
                    n_freed   = r_freed + CW'(1);
                end
            end
            ffua_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    assign o_res.ok    = r_ok;
    assign o_res.start = ffua_pkg::START_W'(r_start);
    assign o_res.freed = ffua_pkg::FREED_W'(r_freed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffua_pkg::S_CLEAR;
            r_addr   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_size  <= n_size;
        r_owner <= n_owner;
        r_lim   <= n_lim;
        r_raddr <= n_raddr;
        r_run   <= n_run;
        r_fill  <= n_fill;
        r_end   <= n_end;
        r_ok    <= n_ok;
        r_start <= n_start;
        r_freed <= n_freed;
    end

endmodule

// ----- sv/ffua_chk.sv -----
// Port-level checker for the first-fit unit allocator and its bind.
module ffua_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_success,
    input logic [ffua_pkg::START_W-1:0]    o_start_unit,
    input logic [ffua_pkg::FREED_W-1:0]    o_freed_units
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request accepted during tag clearing");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request accepted back to back");

    a_fail_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_success |-> o_start_unit == '0 && o_freed_units == '0)
        else $error("failed allocate carries data");

    a_free_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freed_units != '0 |-> o_success && o_start_unit == '0)
        else $error("free result malformed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_success) &&
            $stable(o_start_unit) && $stable(o_freed_units))
        else $error("stalled result changed");

endmodule

bind first_fit_unit_allocator_top ffua_chk u_ffua_chk (.*);

// ----- verif/first_fit_unit_allocator_top_tb.sv -----
// Self-checking testbench for the first-fit unit allocator: directed table, then random requests.
module first_fit_unit_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_UNITS = ffua_pkg::MEM_UNITS_DEF;
    localparam logic [ffua_pkg::ADDR_W-1:0] UNITS_ADDR  = {ffua_pkg::REG_UNITS_IDX, 2'b00};
    localparam logic [ffua_pkg::ADDR_W-1:0] UNUSED_ADDR = {~ffua_pkg::REG_UNITS_IDX, 2'b00};
    localparam int TAIL_CYCLES = 2 * MEM_UNITS + 16;
    localparam int N_PHASES = 10;
    localparam int PHASE_UNITS [N_PHASES] = '{1024, 1, 0, 2047, 16, 1000, 64, 3, 512, 200};
    localparam int PHASE_ITEMS [N_PHASES] = '{70, 30, 25, 60, 70, 70, 70, 30, 75, 80};

    typedef struct packed {
        ffua_pkg::t_req rq;
        logic           known;
        ffua_pkg::t_res want;
    } t_row;

    localparam int N_DIRECTED = 23;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{ffua_pkg::CMD_ALLOC, 11'd1,    10'd1},    1'b1, '{1'b1, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1024, 10'd2},    1'b1, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd2047, 10'd3},    1'b1, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd0,    10'd4},    1'b1, '{1'b1, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd5,    10'd0},    1'b1, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_FREE,  11'd2047, 10'd0},    1'b1, '{1'b1, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_FREE,  11'd0,    10'd1},    1'b1, '{1'b1, 10'd0, 11'd1}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1024, 10'd1023}, 1'b1, '{1'b1, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1,    10'd5},    1'b1, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_FREE,  11'd0,    10'd1023}, 1'b1, '{1'b1, 10'd0, 11'd1024}},
        '{'{ffua_pkg::CMD_FREE,  11'd1,    10'd1023}, 1'b1, '{1'b1, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd3,    10'd6},    1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd4,    10'd7},    1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_FREE,  11'd0,    10'd6},    1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd2,    10'd8},    1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd2,    10'd9},    1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1,    10'd10},   1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1013, 10'd11},   1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd3,    10'd12},   1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd2,    10'd512},  1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_FREE,  11'd0,    10'd11},   1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1,    10'd341},  1'b0, '{1'b0, 10'd0, 11'd0}},
        '{'{ffua_pkg::CMD_ALLOC, 11'd1,    10'd682},  1'b0, '{1'b0, 10'd0, 11'd0}}
    };

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             psel           = 1'b0;
    logic                             penable        = 1'b0;
    logic                             pwrite         = 1'b0;
    logic [ffua_pkg::ADDR_W-1:0]      paddr          = '0;
    logic [ffua_pkg::DATA_W-1:0]      pwdata         = '0;
    logic [ffua_pkg::DATA_W-1:0]      prdata;
    logic                             pready;
    logic                             i_valid        = 1'b0;
    logic                             o_ready;
    logic                             i_command      = ffua_pkg::CMD_ALLOC;
    logic [ffua_pkg::SIZE_W-1:0]      i_request_size = '0;
    logic [ffua_pkg::ID_W-1:0]        i_owner_id     = '0;
    logic                             o_valid;
    logic                             i_ready        = 1'b0;
    logic                             o_success;
    logic [ffua_pkg::START_W-1:0]     o_start_unit;
    logic [ffua_pkg::FREED_W-1:0]     o_freed_units;

    logic [ffua_pkg::ID_W-1:0]  shadow_tags [MEM_UNITS];
    logic [ffua_pkg::CFG_W-1:0] shadow_units = ffua_pkg::UNITS_RESET;
    ffua_pkg::t_res             awaited_results [$];
    ffua_pkg::t_res             want;
    logic                       calm = 1'b0;
    int                         ready_hold = 0;
    int                         ready_pick;
    int                         mismatches = 0;
    int                         total_requests = 0;
    int                         granted = 0;
    int                         refused = 0;
    int                         frees = 0;
    int                         released = 0;

    first_fit_unit_allocator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_request_size(i_request_size),
        .i_owner_id    (i_owner_id),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_success     (o_success),
        .o_start_unit  (o_start_unit),
        .o_freed_units (o_freed_units)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic ffua_pkg::t_res apply_request(input ffua_pkg::t_req rq);
        ffua_pkg::t_res res;
        int   lim;
        int   run;
        int   first;
        res = '0;
        run = 0;
        total_requests++;
        lim = (shadow_units > MEM_UNITS) ? MEM_UNITS : int'(shadow_units);
        if (rq.cmd == ffua_pkg::CMD_FREE) begin
            res.ok = 1'b1;
            frees++;
            if (rq.owner != '0) begin
                for (int u = 0; u < MEM_UNITS; u++) begin
                    if (shadow_tags[u] == rq.owner) begin
                        shadow_tags[u] = '0;
                        res.freed = res.freed + 1'b1;
                    end
                end
            end
            released += int'(res.freed);
        end else begin
            if (rq.owner != '0) begin
                if (rq.size == '0) begin
                    res.ok = 1'b1;
                end else if (int'(rq.size) <= lim) begin
                    for (int u = 0; u < lim; u++) begin
                        run = (shadow_tags[u] == '0) ? run + 1 : 0;
                        if (run == int'(rq.size)) begin
                            first = u + 1 - run;
                            for (int j = first; j <= u; j++) begin
                                shadow_tags[j] = rq.owner;
                            end
                            res.ok = 1'b1;
                            res.start = ffua_pkg::START_W'(first);
                            break;
                        end
                    end
                end
            end
            if (res.ok) granted++;
            else refused++;
        end
        return res;
    endfunction

    function automatic void check_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
            mismatches++;
        end
    endfunction

    task automatic write_register(input logic [ffua_pkg::ADDR_W-1:0] addr,
                                  input logic [ffua_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[ffua_pkg::ADDR_W-1:2] == ffua_pkg::REG_UNITS_IDX) begin
            shadow_units = data[ffua_pkg::CFG_W-1:0];
        end
    endtask

    task automatic send_request(input ffua_pkg::t_req rq, input logic known,
                                input ffua_pkg::t_res typed_res);
        ffua_pkg::t_res predicted;
        i_valid        <= 1'b1;
        i_command      <= rq.cmd;
        i_request_size <= rq.size;
        i_owner_id     <= rq.owner;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_request(rq);
        if (known) predicted = typed_res;
        awaited_results = {awaited_results, predicted};
    endtask

    task automatic rest_sender();
        int gap;
        int pick;
        gap = 0;
        if (!calm) begin
            pick = $urandom_range(99);
            if (pick >= 90) gap = $urandom_range(8, 40);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic await_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0d start %0d freed %0d",
                         $time, "actual success", o_success, o_start_unit, o_freed_units);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("success", int'(want.ok), int'(o_success));
                check_field("start_unit", int'(want.start), int'(o_start_unit));
                check_field("freed_units", int'(want.freed), int'(o_freed_units));
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            ready_pick = $urandom_range(9);
            if (ready_pick < 6) begin
                i_ready    <= 1'b1;
                ready_hold = $urandom_range(0, 5);
            end else if (ready_pick < 9) begin
                i_ready    <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                i_ready    <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    initial begin : stimulus
        ffua_pkg::t_req rq;
        int   lim;
        int   pick;
        int   span;
        foreach (shadow_tags[u]) shadow_tags[u] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_register(UNUSED_ADDR, ffua_pkg::DATA_W'(5));
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_request(DIRECTED[k].rq, DIRECTED[k].known, DIRECTED[k].want);
            rest_sender();
        end
        for (int p = 0; p < N_PHASES; p++) begin
            await_results();
            write_register(UNITS_ADDR, ffua_pkg::DATA_W'(PHASE_UNITS[p]));
            calm = (p % 3 == 1);
            lim = (PHASE_UNITS[p] > MEM_UNITS) ? MEM_UNITS : PHASE_UNITS[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if ($urandom_range(49) == 0) await_results();
                pick = $urandom_range(99);
                rq.cmd = ffua_pkg::CMD_ALLOC;
                rq.size = ffua_pkg::SIZE_W'($urandom_range(0, 2047));
                rq.owner = ffua_pkg::ID_W'($urandom_range(1, 12));
                if ($urandom_range(1) == 1) rq.owner = rq.owner ^ 10'h3F0;
                if ($urandom_range(19) == 0) rq.owner = ffua_pkg::ID_W'($urandom_range(1, 1023));
                if (pick < 50) begin
                    span = $urandom_range(9);
                    if (span < 6) begin
                        rq.size = ffua_pkg::SIZE_W'($urandom_range(1, (lim > 8) ? lim / 8 : 1));
                    end else if (span < 8) begin
                        rq.size = ffua_pkg::SIZE_W'($urandom_range(1, (lim > 1) ? lim : 1));
                    end else if (span == 8) begin
                        rq.size = ffua_pkg::SIZE_W'(lim + $urandom_range(0, 2));
                    end
                end else if (pick < 82) begin
                    rq.cmd = ffua_pkg::CMD_FREE;
                end else if (pick < 90) begin
                    rq.cmd = ffua_pkg::CMD_FREE;
                    rq.owner = ffua_pkg::ID_W'($urandom_range(0, 1023));
                end else if (pick < 95) begin
                    rq.owner = '0;
                end else begin
                    rq.size = '0;
                end
                send_request(rq, 1'b0, '0);
                rest_sender();
            end
        end
        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests over %0d unit-count settings: %0d granted, %0d refused.",
                 total_requests, N_PHASES + 1, granted, refused);
        $display("Ran %0d frees that released %0d units; %0d field mismatches.",
                 frees, released, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("Timeout with %0d results outstanding", awaited_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
